// ===== src/highest_note_skyline_filter_assert.svh =====
// ---------------------------------------------------------------------------
// skyline filter assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef HIGHEST_NOTE_SKYLINE_FILTER_ASSERT_SVH
`define HIGHEST_NOTE_SKYLINE_FILTER_ASSERT_SVH

// same-cycle implication
`define HNSF_ASSERT_IMPLY(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define HNSF_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== src/hnsf_pkg.sv =====
// ---------------------------------------------------------------------------
// hnsf_pkg
// word types and fixed field widths of the skyline melody filter
// ---------------------------------------------------------------------------
package hnsf_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int PITCH_W = 24;
    localparam int LOUD_W  = 16;

    typedef struct packed {
        logic [TIME_W-1:0]  event_time_ms;
        logic               is_note_on;
        logic [ID_W-1:0]    note_id;
        logic [PITCH_W-1:0] pitch;
        logic [LOUD_W-1:0]  loudness;
    } evt_t;

    typedef struct packed {
        logic [TIME_W-1:0]  segment_start_ms;
        logic [TIME_W-1:0]  segment_length_ms;
        logic [PITCH_W-1:0] segment_pitch;
        logic [LOUD_W-1:0]  segment_loudness;
        logic               table_overflowed;
    } seg_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

// ===== src/highest_note_skyline_filter.sv =====
// ---------------------------------------------------------------------------
// highest_note_skyline_filter
// tracks sounding notes in a slot table and emits the top-note melody
// segments of a time-ordered note on/off stream
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | word
//  evt      | in  | evt_valid/stall  | hnsf_pkg::evt_t, one note event
//  seg      | out | seg_valid/stall  | hnsf_pkg::seg_t, one finished segment
//
// each event passes through the idle cycle that accepts it, a sweep of the slot
// memory read port (one slot per cycle), a drain, a write and an update
// reset clears the slot valid bits, the tracked segment and the overflow flag
// a stalled segment word holds the block in its update cycle only when a new
// segment must be emitted; evt is stalled whenever an event is in work
// ---------------------------------------------------------------------------
`include "highest_note_skyline_filter_assert.svh"

module highest_note_skyline_filter #(
    parameter int VOICES  = 16,
    parameter int ID_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            evt_valid,
    output logic            evt_stall,
    input  hnsf_pkg::evt_t  evt,
    output logic            seg_valid,
    input  logic            seg_stall,
    output hnsf_pkg::seg_t  seg
);

    localparam int SW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IDW = (ID_BITS < hnsf_pkg::ID_W) ? ID_BITS : hnsf_pkg::ID_W;
    localparam int PW  = hnsf_pkg::PITCH_W;
    localparam int VW  = hnsf_pkg::LOUD_W;
    localparam int TW  = hnsf_pkg::TIME_W;
    localparam int DW  = IDW + PW + VW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    localparam logic [SW-1:0] LAST_SLOT = SW'(VOICES - 1);

    logic [2:0]          state_reg,  state_next;
    logic [SW-1:0]       cnt_reg,    cnt_next;
    logic                sample_reg, sample_next;
    logic [SW-1:0]       idx_reg,    idx_next;
    hnsf_pkg::evt_t      evt_reg,    evt_next;
    logic [VOICES-1:0]   valid_reg,  valid_next;
    logic                ovf_reg,    ovf_next;
    logic                active_reg, active_next;
    logic [TW-1:0]       start_reg,  start_next;
    logic [PW-1:0]       cur_p_reg,  cur_p_next;
    logic [VW-1:0]       cur_v_reg,  cur_v_next;
    logic [IDW-1:0]      cur_id_reg, cur_id_next;
    logic [PW-1:0]       fin_p_reg,  fin_p_next;
    logic [VW-1:0]       fin_v_reg,  fin_v_next;
    logic [IDW-1:0]      fin_id_reg, fin_id_next;
    logic                seg_valid_reg, seg_valid_next;
    hnsf_pkg::seg_t      seg_reg,    seg_next;

    logic                accept;
    logic [IDW-1:0]      key_id;
    hnsf_pkg::scan_ctl_t scan_ctl;
    logic                mem_we;
    logic [SW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [DW-1:0]       mem_rdata;

    logic                hit_found;
    logic [SW-1:0]       hit_idx;
    logic                free_found;
    logic [SW-1:0]       free_idx;
    logic [PW-1:0]       best_p;
    logic [VW-1:0]       best_v;
    logic [IDW-1:0]      best_id;

    logic                slot_ok;
    logic [SW-1:0]       tgt_slot;
    logic                new_wins;
    logic                changed;
    logic                emit;
    logic                keep;
    logic                out_free;

    assign accept   = evt_valid && !evt_stall;
    assign key_id   = evt_reg.note_id[IDW-1:0];
    assign scan_ctl = '{clear: accept, sample: sample_reg};

    hnsf_slot_mem #(
        .DEPTH (VOICES),
        .AW    (SW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg),
        .rdata (mem_rdata)
    );

    hnsf_scan #(
        .SW  (SW),
        .IDW (IDW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (idx_reg),
        .slot_vld   (valid_reg[idx_reg]),
        .key_id     (key_id),
        .rd_note    (mem_rdata[DW-1 -: IDW]),
        .rd_pitch   (mem_rdata[VW +: PW]),
        .rd_loud    (mem_rdata[VW-1:0]),
        .hit_found  (hit_found),
        .hit_idx    (hit_idx),
        .free_found (free_found),
        .free_idx   (free_idx),
        .best_pitch (best_p),
        .best_loud  (best_v),
        .best_id    (best_id)
    );

    assign slot_ok   = hit_found || free_found;
    assign tgt_slot  = hit_found ? hit_idx : free_idx;
    assign mem_waddr = tgt_slot;
    assign mem_wdata = {key_id, evt_reg.pitch, evt_reg.loudness};
    assign mem_we    = (state_reg == ST_WRITE) && evt_reg.is_note_on && slot_ok;

    // the stored note of this id was left out of the sweep; the new one competes here
    assign new_wins = evt_reg.is_note_on && slot_ok && (evt_reg.pitch != '0) &&
                      ((evt_reg.pitch > best_p) ||
                       ((evt_reg.pitch == best_p) && (key_id < best_id)));

    assign changed  = (fin_p_reg != cur_p_reg) || (fin_id_reg != cur_id_reg);
    assign emit     = active_reg && changed && (evt_reg.event_time_ms > start_reg);
    assign keep     = active_reg && !changed;
    assign out_free = !seg_valid_reg || !seg_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sample_next    = 1'b0;
        idx_next       = idx_reg;
        evt_next       = evt_reg;
        valid_next     = valid_reg;
        ovf_next       = ovf_reg;
        active_next    = active_reg;
        start_next     = start_reg;
        cur_p_next     = cur_p_reg;
        cur_v_next     = cur_v_reg;
        cur_id_next    = cur_id_reg;
        fin_p_next     = fin_p_reg;
        fin_v_next     = fin_v_reg;
        fin_id_next    = fin_id_reg;
        seg_valid_next = seg_valid_reg && seg_stall;
        seg_next       = seg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    evt_next   = evt;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                sample_next = 1'b1;
                idx_next    = cnt_reg;
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = SW'(cnt_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (evt_reg.is_note_on)
                begin
                    if (slot_ok)
                    begin
                        valid_next[tgt_slot] = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (hit_found)
                begin
                    valid_next[hit_idx] = 1'b0;
                end
                fin_p_next  = new_wins ? evt_reg.pitch    : best_p;
                fin_v_next  = new_wins ? evt_reg.loudness : best_v;
                fin_id_next = new_wins ? key_id           : best_id;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        seg_valid_next             = 1'b1;
                        seg_next.segment_start_ms  = start_reg;
                        seg_next.segment_length_ms = evt_reg.event_time_ms - start_reg;
                        seg_next.segment_pitch     = cur_p_reg;
                        seg_next.segment_loudness  = cur_v_reg;
                        seg_next.table_overflowed  = ovf_reg;
                    end
                    if (!keep && (fin_p_reg != '0))
                    begin
                        active_next = 1'b1;
                        start_next  = evt_reg.event_time_ms;
                        cur_p_next  = fin_p_reg;
                        cur_v_next  = fin_v_reg;
                        cur_id_next = fin_id_reg;
                    end
                    else
                    begin
                        active_next = keep;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sample_reg    <= 1'b0;
            valid_reg     <= '0;
            ovf_reg       <= 1'b0;
            active_reg    <= 1'b0;
            start_reg     <= '0;
            cur_p_reg     <= '0;
            cur_v_reg     <= '0;
            cur_id_reg    <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sample_reg    <= sample_next;
            valid_reg     <= valid_next;
            ovf_reg       <= ovf_next;
            active_reg    <= active_next;
            start_reg     <= start_next;
            cur_p_reg     <= cur_p_next;
            cur_v_reg     <= cur_v_next;
            cur_id_reg    <= cur_id_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        evt_reg    <= evt_next;
        fin_p_reg  <= fin_p_next;
        fin_v_reg  <= fin_v_next;
        fin_id_reg <= fin_id_next;
        seg_reg    <= seg_next;
    end

    assign evt_stall = (state_reg != ST_IDLE);
    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    `HNSF_ASSERT_NEXT(a_accept_starts_sweep, accept,
        (state_reg == ST_SCAN) && (cnt_reg == '0), "accepted word did not start a slot sweep")
    `HNSF_ASSERT_NEXT(a_overflow_sticky, ovf_reg, ovf_reg,
        "overflow flag cleared without reset")
    `HNSF_ASSERT_IMPLY(a_seg_len_positive, seg_valid, seg.segment_length_ms != '0,
        "segment word with zero length")
    `HNSF_ASSERT_IMPLY(a_active_has_pitch, active_reg, cur_p_reg != '0,
        "tracked segment without a sounding note")
    `HNSF_ASSERT_IMPLY(a_sample_in_sweep, sample_reg,
        (state_reg == ST_SCAN) || (state_reg == ST_DRAIN), "slot sample outside the sweep")

endmodule

// ===== src/hnsf_slot_mem.sv =====
// ---------------------------------------------------------------------------
// hnsf_slot_mem
// slot table storage, one write port and one registered read port
// ---------------------------------------------------------------------------
module hnsf_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 56
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hnsf_scan.sv =====
// ---------------------------------------------------------------------------
// hnsf_scan
// walks the slot read stream: finds the slot of the event's id, the first
// free slot, and the top note among the other sounding slots
// ---------------------------------------------------------------------------
module hnsf_scan #(
    parameter int SW  = 4,
    parameter int IDW = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hnsf_pkg::scan_ctl_t         ctl,
    input  logic [SW-1:0]               idx,
    input  logic                        slot_vld,
    input  logic [IDW-1:0]              key_id,
    input  logic [IDW-1:0]              rd_note,
    input  logic [hnsf_pkg::PITCH_W-1:0] rd_pitch,
    input  logic [hnsf_pkg::LOUD_W-1:0]  rd_loud,
    output logic                        hit_found,
    output logic [SW-1:0]               hit_idx,
    output logic                        free_found,
    output logic [SW-1:0]               free_idx,
    output logic [hnsf_pkg::PITCH_W-1:0] best_pitch,
    output logic [hnsf_pkg::LOUD_W-1:0]  best_loud,
    output logic [IDW-1:0]              best_id
);

    logic                         hit_reg,  hit_next;
    logic [SW-1:0]                hidx_reg, hidx_next;
    logic                         free_reg, free_next;
    logic [SW-1:0]                fidx_reg, fidx_next;
    logic [hnsf_pkg::PITCH_W-1:0] bp_reg,   bp_next;
    logic [hnsf_pkg::LOUD_W-1:0]  bv_reg,   bv_next;
    logic [IDW-1:0]               bid_reg,  bid_next;
    logic                         match;
    logic                         better;

    assign match  = slot_vld && (rd_note == key_id);
    // ids are unique among sounding slots, so the order of the walk does not matter
    assign better = slot_vld && !match && (rd_pitch != '0) &&
                    ((rd_pitch > bp_reg) || ((rd_pitch == bp_reg) && (rd_note < bid_reg)));

    always_comb
    begin
        hit_next  = hit_reg;
        hidx_next = hidx_reg;
        free_next = free_reg;
        fidx_next = fidx_reg;
        bp_next   = bp_reg;
        bv_next   = bv_reg;
        bid_next  = bid_reg;
        if (ctl.clear)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
            bp_next   = '0;
            bv_next   = '0;
            bid_next  = '0;
        end
        else if (ctl.sample)
        begin
            if (match && !hit_reg)
            begin
                hit_next  = 1'b1;
                hidx_next = idx;
            end
            if (!slot_vld && !free_reg)
            begin
                free_next = 1'b1;
                fidx_next = idx;
            end
            if (better)
            begin
                bp_next  = rd_pitch;
                bv_next  = rd_loud;
                bid_next = rd_note;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            bp_reg   <= '0;
            bid_reg  <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
            bp_reg   <= bp_next;
            bid_reg  <= bid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hidx_reg <= hidx_next;
        fidx_reg <= fidx_next;
        bv_reg   <= bv_next;
    end

    assign hit_found  = hit_reg;
    assign hit_idx    = hidx_reg;
    assign free_found = free_reg;
    assign free_idx   = fidx_reg;
    assign best_pitch = bp_reg;
    assign best_loud  = bv_reg;
    assign best_id    = bid_reg;

endmodule

// ===== dv/tb_highest_note_skyline_filter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_highest_note_skyline_filter
// drives note on/off words into the skyline filter, predicts the melody
// segments it must emit and checks every segment word field by field;
// directed corner events first, then random well-formed note streams with
// some noise, under changing sender and receiver idling
// ---------------------------------------------------------------------------
module tb_highest_note_skyline_filter;

    localparam int VOICES      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * (VOICES + 4);
    localparam int PHASE_ITEMS = 175;

    // tracks the sounding-note table and the open segment, queues the
    // segments that accepted events must close
    class skyline_scoreboard;
        bit                           slot_live  [VOICES];
        logic [hnsf_pkg::ID_W-1:0]    slot_id    [VOICES];
        logic [hnsf_pkg::PITCH_W-1:0] slot_pitch [VOICES];
        logic [hnsf_pkg::LOUD_W-1:0]  slot_loud  [VOICES];
        logic [hnsf_pkg::TIME_W-1:0]  top_start;
        logic [hnsf_pkg::PITCH_W-1:0] top_pitch;
        logic [hnsf_pkg::LOUD_W-1:0]  top_loud;
        logic [hnsf_pkg::ID_W-1:0]    top_id;
        bit                           top_open;
        bit                           dropped_note;
        hnsf_pkg::seg_t               due_segments[$];
        int                           errors;

        function new();
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            top_start    = '0;
            top_pitch    = '0;
            top_loud     = '0;
            top_id       = '0;
            top_open     = 1'b0;
            dropped_note = 1'b0;
            errors       = 0;
        endfunction

        function int pending();
            return due_segments.size();
        endfunction

        function void note_event(hnsf_pkg::evt_t w);
            int                           hit;
            int                           free_slot;
            int                           s;
            logic [hnsf_pkg::PITCH_W-1:0] best_p;
            logic [hnsf_pkg::LOUD_W-1:0]  best_v;
            logic [hnsf_pkg::ID_W-1:0]    best_id;
            hnsf_pkg::seg_t               done;
            hit       = -1;
            free_slot = -1;
            best_p    = '0;
            best_v    = '0;
            best_id   = '0;
            for (int i = 0; i < VOICES; i++)
            begin
                if (slot_live[i] && slot_id[i] == w.note_id)
                begin
                    if (hit < 0)
                        hit = i;
                end
                else if (!slot_live[i] && free_slot < 0)
                    free_slot = i;
            end
            if (w.is_note_on)
            begin
                s = (hit >= 0) ? hit : free_slot;
                if (s >= 0)
                begin
                    slot_live[s]  = 1'b1;
                    slot_id[s]    = w.note_id;
                    slot_pitch[s] = w.pitch;
                    slot_loud[s]  = w.loudness;
                end
                else
                    dropped_note = 1'b1;
            end
            else if (hit >= 0)
                slot_live[hit] = 1'b0;

            // zero-pitch notes hold a slot but never reach the top
            for (int i = 0; i < VOICES; i++)
            begin
                if (!slot_live[i] || slot_pitch[i] == '0)
                    continue;
                if (slot_pitch[i] > best_p || (slot_pitch[i] == best_p && slot_id[i] < best_id))
                begin
                    best_p  = slot_pitch[i];
                    best_v  = slot_loud[i];
                    best_id = slot_id[i];
                end
            end

            if (top_open && (best_p != top_pitch || best_id != top_id))
            begin
                // a segment of zero or negative length is dropped silently
                if (w.event_time_ms > top_start)
                begin
                    done.segment_start_ms  = top_start;
                    done.segment_length_ms = w.event_time_ms - top_start;
                    done.segment_pitch     = top_pitch;
                    done.segment_loudness  = top_loud;
                    done.table_overflowed  = dropped_note;
                    due_segments = {due_segments, done};
                end
                top_open = 1'b0;
            end
            if (best_p != '0 && !top_open)
            begin
                top_start = w.event_time_ms;
                top_pitch = best_p;
                top_loud  = best_v;
                top_id    = best_id;
                top_open  = 1'b1;
            end
        endfunction

        function bit field_ok(string name, logic [hnsf_pkg::TIME_W-1:0] want,
                              logic [hnsf_pkg::TIME_W-1:0] got);
            if (want === got)
                return 1'b1;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1'b0;
        endfunction

        function void check_segment(hnsf_pkg::seg_t got);
            hnsf_pkg::seg_t want;
            bit             ok;
            if (due_segments.size() == 0)
            begin
                $display("%0t: segment expected none got %h", $time, got);
                errors++;
                return;
            end
            want = due_segments.pop_front();
            ok = field_ok("segment_start_ms", want.segment_start_ms, got.segment_start_ms);
            ok &= field_ok("segment_length_ms", want.segment_length_ms, got.segment_length_ms);
            ok &= field_ok("segment_pitch", want.segment_pitch, got.segment_pitch);
            ok &= field_ok("segment_loudness", want.segment_loudness, got.segment_loudness);
            ok &= field_ok("table_overflowed", want.table_overflowed, got.table_overflowed);
            if (!ok)
                errors++;
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           evt_valid;
    logic           evt_stall;
    hnsf_pkg::evt_t evt;
    logic           seg_valid;
    logic           seg_stall;
    hnsf_pkg::seg_t seg;

    skyline_scoreboard            sb;
    int                           tx_idle;
    int                           rx_idle;
    int                           cycles;
    logic [hnsf_pkg::TIME_W-1:0]  now_ms;
    logic [hnsf_pkg::ID_W-1:0]    sounding[$];
    logic [hnsf_pkg::PITCH_W-1:0] pitch_pool[4];

    highest_note_skyline_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_highest_note_skyline_filter failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_valid && !evt_stall)
                sb.note_event(evt);
            if (seg_valid && !seg_stall)
                sb.check_segment(seg);
        end
    end

    always @(negedge clk)
        seg_stall <= ($urandom_range(99) < rx_idle);

    // presents one word, returns at the edge where it is taken
    task automatic send_word(input hnsf_pkg::evt_t w);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= w;
        do
            @(posedge clk);
        while (evt_stall);
    endtask

    task automatic play(input logic [hnsf_pkg::TIME_W-1:0] t, input bit on,
                        input logic [hnsf_pkg::ID_W-1:0] id,
                        input logic [hnsf_pkg::PITCH_W-1:0] p,
                        input logic [hnsf_pkg::LOUD_W-1:0] v);
        hnsf_pkg::evt_t w;
        int             k;
        k = -1;
        foreach (sounding[i])
            if (sounding[i] == id && k < 0)
                k = i;
        if (on && k < 0)
            sounding = {sounding, id};
        else if (!on && k >= 0)
            sounding.delete(k);
        w.event_time_ms = t;
        w.is_note_on    = on;
        w.note_id       = id;
        w.pitch         = p;
        w.loudness      = v;
        send_word(w);
    endtask

    task automatic random_event(input int on_pct);
        logic [hnsf_pkg::ID_W-1:0]    id;
        logic [hnsf_pkg::PITCH_W-1:0] p;
        bit                           on;
        int                           pick;
        pick = $urandom_range(99);
        if (pick < 4)
            now_ms = now_ms + $urandom;
        else if (pick >= 30)
            now_ms = now_ms + $urandom_range(1, 40);

        // noise: any on/off flag, id and pitch the fields allow, loudness up to 32768
        if ($urandom_range(99) < 5)
        begin
            play(now_ms, 1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom),
                 16'($urandom_range(0, 32768)));
            return;
        end

        on = (sounding.size() == 0) || (sounding.size() < 20 && $urandom_range(99) < on_pct);
        if (on)
        begin
            if (sounding.size() > 0 && $urandom_range(9) == 0)
                id = sounding[$urandom_range(sounding.size() - 1)];
            else
                id = 16'($urandom);
            pick = $urandom_range(49);
            if (pick == 0)
                p = '0;
            else if (pick < 15)
                p = pitch_pool[$urandom_range(3)];
            else
                p = 24'($urandom_range(1, 24'hFFFFFF));
            play(now_ms, 1'b1, id, p, 16'($urandom_range(0, 32768)));
        end
        else
        begin
            if ($urandom_range(9) == 0)
                id = 16'($urandom);
            else
                id = sounding[$urandom_range(sounding.size() - 1)];
            play(now_ms, 1'b0, id, 24'($urandom), 16'($urandom_range(0, 32768)));
        end
    endtask

    initial
    begin
        int on_pct;
        sb        = new();
        cycles    = 0;
        tx_idle   = 31;
        rx_idle   = 60;
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt       = '0;
        seg_stall = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // equal pitches, repeated on, off of a silent id, zero pitch,
        // zero-length segment, then fill the table past full
        play(32'd0, 1'b1, 16'h0000, 24'hFFFFFF, 16'h8000);
        play(32'd0, 1'b1, 16'hFFFF, 24'hFFFFFF, 16'h0000);
        play(32'd5, 1'b1, 16'h0000, 24'hFFFFFF, 16'd100);
        play(32'd10, 1'b0, 16'h0000, 24'hFFFFFF, 16'h8000);
        play(32'd10, 1'b0, 16'h1234, 24'h000001, 16'h0000);
        play(32'd10, 1'b1, 16'h0007, 24'h000000, 16'h7FFF);
        play(32'd12, 1'b0, 16'hFFFF, 24'h000000, 16'h0000);
        play(32'd12, 1'b1, 16'h0003, 24'h000001, 16'h0001);
        play(32'd12, 1'b1, 16'h0004, 24'h000002, 16'h0002);
        for (int k = 0; k < 15; k++)
            play(32'(13 + k), 1'b1, 16'(100 + k), 24'(256 + k), 16'(1000 * k));
        play(32'hFFFF_FFFF, 1'b0, 16'd112, 24'hABCDEF, 16'h8000);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 31 : (phase == 1) ? 60 : 0;
            rx_idle = (phase == 0) ? 60 : (phase == 1) ? 31 : 0;
            now_ms  = $urandom;
            foreach (pitch_pool[i])
                pitch_pool[i] = 24'($urandom_range(1, 24'hFFFFFF));
            on_pct = 55;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // bursts with more ons push the table to overflow
                if (n % 40 == 0)
                    on_pct = ($urandom_range(2) == 0) ? 45 : ($urandom_range(1) ? 55 : 70);
                random_event(on_pct);
            end
        end
        @(negedge clk);
        evt_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_highest_note_skyline_filter passed");
        else
            $display("tb_highest_note_skyline_filter failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/hnsf_pkg.sv
src/hnsf_slot_mem.sv
src/hnsf_scan.sv
src/highest_note_skyline_filter.sv
dv/tb_highest_note_skyline_filter.sv
